// ===== hw/rtl/utf8_validating_decoder_core_assert.svh =====
// assertion macros used by the checker file
`ifndef UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define UTF8DEC_ASSERT_SAME(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("utf8 decoder check failed");

// condition in this cycle implies consequence later, after the delay given by dly
`define UTF8DEC_ASSERT_LATER(label, clk, rst, cond, dly, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##dly (conseq)) \
      else $error("utf8 decoder check failed");

`endif

// ===== hw/rtl/utf8dec_pkg.sv =====
// types and constants for the utf8 validating decoder
`default_nettype none
package utf8dec_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned COUNT_W = 3;

   // status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // lead byte classes and limits
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
   localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
   localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;

   localparam logic [CP_W-1:0] MIN_TWO      = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE    = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR     = 21'h010000;
   localparam logic [CP_W-1:0] SURR_LOW     = 21'h00d800;
   localparam logic [CP_W-1:0] SURR_HIGH    = 21'h00dfff;
   localparam logic [CP_W-1:0] MAX_THREE    = 21'h00fffd;
   localparam logic [CP_W-1:0] MAX_SCALAR   = 21'h10ffff;

   localparam logic [COUNT_W-1:0] COUNT_NONE  = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] COUNT_FOUR  = 3'd4;

   // one decoded character
   typedef struct packed {
      logic [CP_W-1:0]    code_point;
      logic [COUNT_W-1:0] byte_count;
      logic               status;
   } decode_result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/utf8dec_decode.sv =====
// combinational decode of one utf8 character from a four-byte window
`default_nettype none
module utf8dec_decode
   import utf8dec_pkg::*;
(
   input  wire logic [BYTE_W-1:0] lead_byte,
   input  wire logic [BYTE_W-1:0] second_byte,
   input  wire logic [BYTE_W-1:0] third_byte,
   input  wire logic [BYTE_W-1:0] fourth_byte,
   output decode_result_type      result
);

   logic              cont1;
   logic              cont2;
   logic              cont3;
   logic [CP_W-1:0]   cp1;
   logic [CP_W-1:0]   cp2;
   logic [CP_W-1:0]   cp3;
   logic [CP_W-1:0]   cp4;
   logic              ok;
   logic [CP_W-1:0]   cp;
   logic [COUNT_W-1:0] len;

   // continuation tags
   assign cont1 = (second_byte & CONT_MASK) == CONT_TAG;
   assign cont2 = (third_byte  & CONT_MASK) == CONT_TAG;
   assign cont3 = (fourth_byte & CONT_MASK) == CONT_TAG;

   // candidate values for each length
   assign cp1 = {13'd0, lead_byte};
   assign cp2 = {10'd0, lead_byte[4:0], second_byte[5:0]};
   assign cp3 = {5'd0, lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
   assign cp4 = {lead_byte[2:0], second_byte[5:0], third_byte[5:0], fourth_byte[5:0]};

   // classify the lead byte and check the value range
   always_comb begin
      ok  = 1'b0;
      cp  = '0;
      len = COUNT_NONE;
      priority if (lead_byte == '0) begin
         ok = 1'b0;
      end else if (lead_byte[7] == 1'b0) begin
         cp  = cp1;
         len = COUNT_ONE;
         ok  = (lead_byte >= CTRL_LIMIT) || (lead_byte == CHAR_TAB) ||
               (lead_byte == CHAR_LF) || (lead_byte == CHAR_CR);
      end else if (lead_byte[7:5] == 3'b110) begin
         cp  = cp2;
         len = COUNT_TWO;
         ok  = cont1 && (cp2 >= MIN_TWO);
      end else if (lead_byte[7:4] == 4'b1110) begin
         cp  = cp3;
         len = COUNT_THREE;
         ok  = cont1 && cont2 && (cp3 >= MIN_THREE) &&
               !((cp3 >= SURR_LOW) && (cp3 <= SURR_HIGH)) && (cp3 <= MAX_THREE);
      end else if (lead_byte[7:3] == 5'b11110) begin
         cp  = cp4;
         len = COUNT_FOUR;
         ok  = cont1 && cont2 && cont3 && (cp4 >= MIN_FOUR) && (cp4 <= MAX_SCALAR);
      end else begin
         ok = 1'b0;
      end
   end

   // errors give zero value and count
   always_comb begin
      if (ok) begin
         result.code_point = cp;
         result.byte_count = len;
         result.status     = STATUS_OK;
      end else begin
         result.code_point = '0;
         result.byte_count = COUNT_NONE;
         result.status     = STATUS_ERR;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_validating_decoder_core.sv =====
// top level of the utf8 validating decoder
//
//   channel   ports                       handshake
//   request   req_*_byte                  start high, busy low
//   result    rsp_code_point/count/status rsp_strobe, one cycle, no stall
//
// one request is taken every cycle start is high and busy low;
// its result passes the input and result registers around the decode logic
// reset is synchronous; busy is high while reset is high and drops with it
// nothing in flight survives reset
// the receiver cannot stall, so busy never rises outside reset
`default_nettype none
module utf8_validating_decoder_core
   import utf8dec_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [BYTE_W-1:0]   req_lead_byte,
   input  wire logic [BYTE_W-1:0]   req_second_byte,
   input  wire logic [BYTE_W-1:0]   req_third_byte,
   input  wire logic [BYTE_W-1:0]   req_fourth_byte,
   output logic                     rsp_strobe,
   output logic [CP_W-1:0]          rsp_code_point,
   output logic [COUNT_W-1:0]       rsp_byte_count,
   output logic                     rsp_status
);

   logic              req_valid_ff;
   logic              req_valid_in;
   logic [BYTE_W-1:0] lead_ff;
   logic [BYTE_W-1:0] second_ff;
   logic [BYTE_W-1:0] third_ff;
   logic [BYTE_W-1:0] fourth_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   decode_result_type result_ff;
   decode_result_type result_in;

   assign busy         = reset;
   assign req_valid_in = start && !busy;
   assign rsp_valid_in = req_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_valid_in) begin
         lead_ff   <= req_lead_byte;
         second_ff <= req_second_byte;
         third_ff  <= req_third_byte;
         fourth_ff <= req_fourth_byte;
      end
   end

   // decode logic
   utf8dec_decode u_decode (
      .lead_byte   (lead_ff),
      .second_byte (second_ff),
      .third_byte  (third_ff),
      .fourth_byte (fourth_ff),
      .result      (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_valid_in) begin
         result_ff <= result_in;
      end
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_code_point = result_ff.code_point;
   assign rsp_byte_count = result_ff.byte_count;
   assign rsp_status     = result_ff.status;

endmodule
`default_nettype wire

// ===== hw/rtl/utf8dec_checker.sv =====
// port-level checks for the utf8 validating decoder, bound to the top level
`default_nettype none
`include "utf8_validating_decoder_core_assert.svh"
module utf8dec_checker
   import utf8dec_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_strobe,
   input wire logic [CP_W-1:0]     rsp_code_point,
   input wire logic [COUNT_W-1:0]  rsp_byte_count,
   input wire logic                rsp_status
);

   // every accepted request yields a result, after the input and result registers
   `UTF8DEC_ASSERT_LATER(a_request_answered, clock, reset, start && !busy, 2, rsp_strobe)

   // an error carries zero value and count
   `UTF8DEC_ASSERT_SAME(a_error_zeroed, clock, reset,
      rsp_strobe && (rsp_status == STATUS_ERR),
      (rsp_code_point == '0) && (rsp_byte_count == COUNT_NONE))

   // a success has a legal count and scalar value
   `UTF8DEC_ASSERT_SAME(a_success_legal, clock, reset,
      rsp_strobe && (rsp_status == STATUS_OK),
      (rsp_byte_count != COUNT_NONE) && (rsp_byte_count <= COUNT_FOUR) &&
      (rsp_code_point <= MAX_SCALAR))

endmodule

bind utf8_validating_decoder_core utf8dec_checker u_checker (.*);
`default_nettype wire

// ===== sim/utf8_validating_decoder_core_tb.sv =====
// self-checking bench for the utf8 validating decoder core
module utf8_validating_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import utf8dec_pkg::*;

   localparam int RANDOM_WINDOWS = 1400;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;
   localparam int IDLE_PCT       = 31;
   localparam int QUIET_FIRST    = 600;
   localparam int QUIET_LAST     = 900;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [BYTE_W-1:0] req_lead_byte   = '0;
   logic [BYTE_W-1:0] req_second_byte = '0;
   logic [BYTE_W-1:0] req_third_byte  = '0;
   logic [BYTE_W-1:0] req_fourth_byte = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [CP_W-1:0]    rsp_code_point;
   logic [COUNT_W-1:0] rsp_byte_count;
   logic               rsp_status;

   logic [31:0]       pending_windows [$];
   decode_result_type expected_chars [$];
   logic              req_taken = 1'b0;
   int                n_total = 0;
   int                n_accepted = 0;
   int                n_errors = 0;
   int                n_rejected = 0;
   int                cycle_count = 0;
   int                n_chars_by_count [5] = '{default: 0};

   utf8_validating_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_lead_byte   (req_lead_byte),
      .req_second_byte (req_second_byte),
      .req_third_byte  (req_third_byte),
      .req_fourth_byte (req_fourth_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_code_point  (rsp_code_point),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_status      (rsp_status)
   );

   always #1 clock = ~clock;

   function automatic logic is_tail(input logic [BYTE_W-1:0] b);
      return (b & CONT_MASK) == CONT_TAG;
   endfunction

   // expected decode of one four-byte window
   function automatic decode_result_type decode_window(input logic [BYTE_W-1:0] b0,
                                                       input logic [BYTE_W-1:0] b1,
                                                       input logic [BYTE_W-1:0] b2,
                                                       input logic [BYTE_W-1:0] b3);
      decode_result_type res;
      logic [CP_W-1:0]    cp;
      logic [COUNT_W-1:0] n;
      logic               ok;
      cp = '0;
      n  = COUNT_NONE;
      ok = 1'b0;
      if (b0 == '0) begin
         ok = 1'b0;
      end else if (!b0[7]) begin
         n  = COUNT_ONE;
         cp = {13'd0, b0};
         ok = !(b0 < CTRL_LIMIT && b0 != CHAR_TAB && b0 != CHAR_LF && b0 != CHAR_CR);
      end else if (b0[7:5] == 3'b110) begin
         n = COUNT_TWO;
         if (is_tail(b1)) begin
            cp = {10'd0, b0[4:0], b1[5:0]};
            ok = cp >= MIN_TWO;
         end
      end else if (b0[7:4] == 4'b1110) begin
         n = COUNT_THREE;
         if (is_tail(b1) && is_tail(b2)) begin
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            ok = !(cp < MIN_THREE || (cp >= SURR_LOW && cp <= SURR_HIGH) || cp > MAX_THREE);
         end
      end else if (b0[7:3] == 5'b11110) begin
         n = COUNT_FOUR;
         if (is_tail(b1) && is_tail(b2) && is_tail(b3)) begin
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            ok = !(cp < MIN_FOUR || cp > MAX_SCALAR);
         end
      end
      if (ok) begin
         res.code_point = cp;
         res.byte_count = n;
         res.status     = STATUS_OK;
      end else begin
         res.code_point = '0;
         res.byte_count = COUNT_NONE;
         res.status     = STATUS_ERR;
      end
      return res;
   endfunction

   // continuation byte, leaning on the ends of its range
   function automatic logic [BYTE_W-1:0] tail_byte();
      case ($urandom_range(0, 3))
         0: return CONT_TAG;
         1: return CONT_TAG | 8'h3f;
         default: return CONT_TAG | 8'($urandom_range(0, 63));
      endcase
   endfunction

   // mostly well-formed characters with random content, some broken, some noise
   function automatic logic [31:0] random_window();
      logic [BYTE_W-1:0] b [4];
      int unsigned       pick;
      int unsigned       len;
      pick = $urandom_range(0, 99);
      for (int i = 0; i < 4; i++) b[i] = 8'($urandom);
      len = 1;
      if (pick < 15) begin
         b[0] = 8'($urandom_range(0, 127));
      end else if (pick < 35) begin
         len  = 2;
         b[0] = 8'hc0 | 8'($urandom_range(0, 31));
      end else if (pick < 60) begin
         len = 3;
         case ($urandom_range(0, 3))
            0: b[0] = 8'he0;
            1: b[0] = 8'hed;
            2: b[0] = 8'hef;
            default: b[0] = 8'he0 | 8'($urandom_range(0, 15));
         endcase
      end else if (pick < 85) begin
         len = 4;
         case ($urandom_range(0, 2))
            0: b[0] = 8'hf0;
            1: b[0] = 8'hf4;
            default: b[0] = 8'hf0 | 8'($urandom_range(0, 7));
         endcase
      end else begin
         return $urandom;
      end
      for (int i = 1; i < len; i++) b[i] = tail_byte();
      // break one continuation byte now and then
      if (len > 1 && $urandom_range(0, 9) == 0) b[$urandom_range(1, len - 1)] = 8'($urandom);
      // end of text right after the character
      if ($urandom_range(0, 3) == 0) begin
         for (int i = len; i < 4; i++) b[i] = '0;
      end
      return {b[0], b[1], b[2], b[3]};
   endfunction

   // request acceptance and result checking
   always @(posedge clock) begin
      decode_result_type want;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (expected_chars.size() == 0) begin
               if (n_errors < MAX_REPORTS)
                  $display("unexpected result: cp %h count %0d status %b",
                           rsp_code_point, rsp_byte_count, rsp_status);
               n_errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_code_point !== want.code_point || rsp_byte_count !== want.byte_count ||
                   rsp_status !== want.status) begin
                  if (n_errors < MAX_REPORTS)
                     $display("mismatch: want cp %h cnt %0d st %b, got cp %h cnt %0d st %b",
                              want.code_point, want.byte_count, want.status,
                              rsp_code_point, rsp_byte_count, rsp_status);
                  n_errors++;
               end
               if (want.status == STATUS_ERR) n_rejected++;
               else n_chars_by_count[want.byte_count]++;
            end
         end
         if (start && !busy) begin
            expected_chars.push_back(decode_window(req_lead_byte, req_second_byte,
                                                   req_third_byte, req_fourth_byte));
            n_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // request driver with random gaps and one quiet stretch
   always @(negedge clock) begin
      logic [31:0] win;
      logic        quiet;
      quiet = n_accepted >= QUIET_FIRST && n_accepted < QUIET_LAST;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_windows.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            win = pending_windows.pop_front();
            start           <= 1'b1;
            req_lead_byte   <= win[31:24];
            req_second_byte <= win[23:16];
            req_third_byte  <= win[15:8];
            req_fourth_byte <= win[7:0];
         end else begin
            start           <= 1'b0;
            req_lead_byte   <= 8'($urandom);
            req_second_byte <= 8'($urandom);
            req_third_byte  <= 8'($urandom);
            req_fourth_byte <= 8'($urandom);
         end
      end
   end

   initial begin
      pending_windows = {
         // end of text, allowed and disallowed control characters
         32'h00000000, 32'h09000000, 32'h0a000000, 32'h0d000000, 32'h1f414141,
         32'h7f000000,
         // bad lead bytes
         32'h80808080, 32'hf8808080, 32'hffffffff,
         // two-byte limits, overlong, bad continuation
         32'hc2800000, 32'hdfbf4141, 32'hc1bf0000, 32'hc3410000,
         // three-byte limits, overlong, surrogates, noncharacters
         32'he0a08000, 32'he09fbf00, 32'hed9fbf00, 32'heda08000, 32'hefbfbd00,
         32'hefbfbe00, 32'hefbfbf00,
         // four-byte limits, overlong, out of range, bad continuation
         32'hf0908080, 32'hf08fbfbf, 32'hf48fbfbf, 32'hf4908080, 32'hf180807f
      };
      repeat (RANDOM_WINDOWS) pending_windows.push_back(random_window());
      n_total = pending_windows.size();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while ((n_accepted < n_total || expected_chars.size() != 0) && cycle_count < CYCLE_LIMIT)
         @(negedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d requests taken",
                  cycle_count, n_accepted, n_total);
         n_errors++;
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
      end
      n_errors += expected_chars.size();
      $display("%0d windows decoded: %0d/%0d/%0d/%0d one/two/three/four byte, %0d rejected",
               n_accepted, n_chars_by_count[1], n_chars_by_count[2], n_chars_by_count[3],
               n_chars_by_count[4], n_rejected);
      $display("%0d failures in %0d cycles", n_errors, cycle_count);
      if (n_errors == 0)
         $display("utf8_validating_decoder_core regression: pass");
      else
         $display("utf8_validating_decoder_core regression: fail");
      $finish;
   end

endmodule

// ===== utf8_validating_decoder_core.f =====
+incdir+hw/rtl
hw/rtl/utf8dec_pkg.sv
hw/rtl/utf8dec_decode.sv
hw/rtl/utf8_validating_decoder_core.sv
hw/rtl/utf8dec_checker.sv
sim/utf8_validating_decoder_core_tb.sv
